// File: rtl/thrm_pkg.sv
// shared constants and types for the two-heap running median
package thrm_pkg;
  localparam int HEAP_DEPTH = 1024;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = $clog2(HEAP_DEPTH);
  localparam int CNT_BITS   = ADDR_BITS + 1;

  typedef logic [VALUE_BITS-1:0] key_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOSET = 2'd2;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_PAIR  = 1'b1;

  // command to a heap engine
  typedef struct packed {
    logic push;
    logic pop;
    key_t key;
  } heap_cmd_t;

  // status back from a heap engine
  typedef struct packed {
    logic busy;
    key_t top;
    key_t popped;
    cnt_t count;
  } heap_stat_t;

  function automatic key_t to_key(input logic [VALUE_BITS-1:0] raw);
    to_key = raw ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
  endfunction
endpackage

// File: rtl/thrm_heap.sv
// one binary heap in a synchronous memory, push by sift up and pop by sift down
module thrm_heap (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                is_max,
  input  logic                clear,
  input  thrm_pkg::heap_cmd_t cmd,
  output thrm_pkg::heap_stat_t stat
);
  import thrm_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UPRD  = 4'd1;
  localparam logic [3:0] S_UPCMP = 4'd2;
  localparam logic [3:0] S_DNRD  = 4'd3;
  localparam logic [3:0] S_DNR2  = 4'd4;
  localparam logic [3:0] S_DNCMP = 4'd5;
  localparam logic [3:0] S_LAST  = 4'd6;
  localparam logic [3:0] S_LASTW = 4'd7;

  key_t mem [HEAP_DEPTH];
  key_t rd_data_r;
  addr_t rd_addr;
  logic  wr_en;
  addr_t wr_addr;
  key_t  wr_data;

  logic [3:0] state_r, state_nxt;
  cnt_t  cnt_r, cnt_nxt;
  addr_t idx_r, idx_nxt;
  key_t  key_r, key_nxt;
  key_t  top_r, top_nxt;
  key_t  popped_r, popped_nxt;
  key_t  lkey_r, lkey_nxt;
  cnt_t  lim_r, lim_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  function automatic logic bef(input key_t a, input key_t b, input logic mx);
    bef = mx ? (a > b) : (a < b);
  endfunction

  cnt_t  par_c, lc, rc;
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    key_nxt    = key_r;
    top_nxt    = top_r;
    popped_nxt = popped_r;
    lkey_nxt   = lkey_r;
    lim_nxt    = lim_r;
    rd_addr    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = key_r;
    par_c      = ({1'b0, idx_r} - cnt_t'(1)) >> 1;
    lc         = {idx_r, 1'b1};
    rc         = lc + cnt_t'(1);
    unique case (state_r)
      S_IDLE: begin
        if (clear) begin
          cnt_nxt = '0;
        end else if (cmd.push) begin
          key_nxt = cmd.key;
          idx_nxt = addr_t'(cnt_r);
          cnt_nxt = cnt_r + cnt_t'(1);
          if (cnt_r == '0) begin
            wr_en = 1'b1; wr_addr = '0; wr_data = cmd.key;
            top_nxt = cmd.key;
          end else begin
            rd_addr = addr_t'(({1'b0, addr_t'(cnt_r)} - cnt_t'(1)) >> 1);
            state_nxt = S_UPRD;
          end
        end else if (cmd.pop) begin
          popped_nxt = top_r;
          cnt_nxt = cnt_r - cnt_t'(1);
          lim_nxt = cnt_r - cnt_t'(1);
          rd_addr = addr_t'(cnt_r - cnt_t'(1));
          state_nxt = S_LAST;
        end
      end
      S_UPRD: begin
        // keep the parent on the read port so its data is there for the compare
        rd_addr = addr_t'(par_c);
        state_nxt = S_UPCMP;
      end
      S_UPCMP: begin
        // parent data is in rd_data_r, parent index from idx_r
        if (bef(key_r, rd_data_r, is_max)) begin
          wr_en = 1'b1; wr_data = rd_data_r;
          idx_nxt = addr_t'(par_c);
          if (par_c == '0) begin
            state_nxt = S_LASTW;
          end else begin
            rd_addr = addr_t'(({1'b0, addr_t'(par_c)} - cnt_t'(1)) >> 1);
            state_nxt = S_UPRD;
          end
        end else begin
          state_nxt = S_LASTW;
        end
      end
      S_LAST: begin
        key_nxt = rd_data_r;
        idx_nxt = '0;
        if (lim_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DNRD;
        end
      end
      S_DNRD: begin
        if (lc >= lim_r) begin
          state_nxt = S_LASTW;
        end else begin
          rd_addr = addr_t'(lc);
          state_nxt = S_DNR2;
        end
      end
      S_DNR2: begin
        lkey_nxt = rd_data_r;
        if (rc < lim_r) begin
          rd_addr = addr_t'(rc);
          state_nxt = S_DNCMP;
        end else begin
          lkey_nxt = rd_data_r;
          state_nxt = S_DNCMP;
          lim_nxt = lim_r;
        end
        // flag single child by reading left again
        if (!(rc < lim_r)) rd_addr = addr_t'(lc);
      end
      S_DNCMP: begin
        if ((rc < lim_r) && bef(rd_data_r, lkey_r, is_max)) begin
          if (bef(rd_data_r, key_r, is_max)) begin
            wr_en = 1'b1; wr_data = rd_data_r;
            idx_nxt = addr_t'(rc);
            state_nxt = S_DNRD;
          end else state_nxt = S_LASTW;
        end else begin
          if (bef(lkey_r, key_r, is_max)) begin
            wr_en = 1'b1; wr_data = lkey_r;
            idx_nxt = addr_t'(lc);
            state_nxt = S_DNRD;
          end else state_nxt = S_LASTW;
        end
      end
      S_LASTW: begin
        wr_en = 1'b1;
        if (idx_r == '0) top_nxt = key_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // the root copy follows every write to entry zero
    if (wr_en && wr_addr == '0) top_nxt = wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    idx_r    <= idx_nxt;
    key_r    <= key_nxt;
    top_r    <= top_nxt;
    popped_r <= popped_nxt;
    lkey_r   <= lkey_nxt;
    lim_r    <= lim_nxt;
  end

  assign stat.busy   = (state_r != S_IDLE);
  assign stat.top    = top_r;
  assign stat.popped = popped_r;
  assign stat.count  = cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(HEAP_DEPTH)) else $error("heap count beyond depth");
  a_no_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !(cmd.push || cmd.pop)) else $error("command while busy");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cmd.push && !clear) |=> cnt_r == $past(cnt_r) + cnt_t'(1))
    else $error("push count");
endmodule

// File: rtl/two_heap_running_median.sv
// top level: request sequencer over two heap engines
// A start beat clears the set and holds its value; it gives no result. A pair beat gives one
// result with the median of all values held. Both heaps live in synchronous memories with one
// read and one write port; a push sifts up one level through a read state and a compare state,
// and a pop sifts down one level through reading the left child, the right child and a compare.
// The time a pair takes from acceptance to result is set by the sift depths of the two inserts
// and their rebalancing moves; a refused pair goes straight to the wait state that writes the
// result, and a start pushes its value through the move state. Items are taken one at a time;
// the result register lets the next beat in while a result still waits. Memories need no clearing pass after reset.
module two_heap_running_median (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic signed [31:0]   in_value_a,
  input  logic signed [31:0]   in_value_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_median,
  output logic [1:0]           out_status
);
  import thrm_pkg::*;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_INS  = 3'd1;
  localparam logic [2:0] P_BAL  = 3'd2;
  localparam logic [2:0] P_MOVE = 3'd3;
  localparam logic [2:0] P_WAIT = 3'd4;
  localparam logic [2:0] P_OUT  = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic started_r, started_nxt;
  logic second_r, second_nxt;
  key_t vb_r, vb_nxt;
  key_t cur_r, cur_nxt;
  logic ov_r, ov_nxt;
  logic [31:0] om_r, om_nxt;
  logic [1:0] os_r, os_nxt;
  logic [1:0] pst_r, pst_nxt;
  logic mv_lo_r, mv_lo_nxt;

  heap_cmd_t  lcmd, ucmd;
  heap_stat_t lst, ust;
  logic clr;

  thrm_heap u_lo (.clk, .rst_n, .is_max(1'b1), .clear(clr), .cmd(lcmd), .stat(lst));
  thrm_heap u_hi (.clk, .rst_n, .is_max(1'b0), .clear(clr), .cmd(ucmd), .stat(ust));

  wire busy = lst.busy | ust.busy;
  wire in_acc = in_valid && !in_stall;
  assign in_stall = (st_r != P_IDLE);
  cnt_t big;
  assign big = (lst.count > ust.count) ? lst.count : ust.count;
  key_t mid;
  assign mid = (ust.count > lst.count) ? ust.top : lst.top;

  always_comb begin
    st_nxt = st_r; started_nxt = started_r; second_nxt = second_r;
    vb_nxt = vb_r; cur_nxt = cur_r; ov_nxt = ov_r; om_nxt = om_r; os_nxt = os_r;
    pst_nxt = pst_r;
    mv_lo_nxt = mv_lo_r;
    lcmd = '0; ucmd = '0; clr = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      P_IDLE: if (in_acc) begin
        if (in_req_type == REQ_START) begin
          clr = 1'b1;
          started_nxt = 1'b1;
          cur_nxt = to_key(in_value_a);
          st_nxt = P_MOVE; mv_lo_nxt = 1'b1; // push start value to lower
        end else if (!started_r) begin
          pst_nxt = ST_NOSET; second_nxt = 1'b1; st_nxt = P_WAIT;
        end else if (big + cnt_t'(1) > cnt_t'(HEAP_DEPTH)) begin
          pst_nxt = ST_FULL; second_nxt = 1'b1; st_nxt = P_WAIT;
        end else begin
          cur_nxt = to_key(in_value_a);
          vb_nxt = to_key(in_value_b);
          second_nxt = 1'b0;
          pst_nxt = ST_OK;
          st_nxt = P_INS;
        end
      end
      P_INS: if (!busy) begin
        if (lst.count != '0 && cur_r > lst.top) ucmd.push = 1'b1;
        else lcmd.push = 1'b1;
        ucmd.key = cur_r; lcmd.key = cur_r;
        st_nxt = P_BAL;
      end
      P_BAL: if (!busy) begin
        if (lst.count > ust.count + cnt_t'(1)) begin
          lcmd.pop = 1'b1; mv_lo_nxt = 1'b0; st_nxt = P_MOVE;
        end else if (ust.count > lst.count + cnt_t'(1)) begin
          ucmd.pop = 1'b1; mv_lo_nxt = 1'b1; st_nxt = P_MOVE;
        end else st_nxt = P_WAIT;
      end
      P_MOVE: if (!busy) begin
        // push into the other heap; start request pushes cur_r into lower
        if (mv_lo_r) begin
          lcmd.push = 1'b1;
          lcmd.key = (ust.count == '0 && lst.count == '0) ? cur_r : ust.popped;
        end else begin
          ucmd.push = 1'b1; ucmd.key = lst.popped;
        end
        st_nxt = (ust.count == '0 && lst.count == '0) ? P_OUT : P_WAIT;
      end
      P_WAIT: if (!busy) begin
        if (!second_r) begin
          second_nxt = 1'b1; cur_nxt = vb_r; st_nxt = P_INS;
        end else if (!ov_r) begin
          ov_nxt = 1'b1;
          om_nxt = (pst_r == ST_OK) ? (mid ^ {1'b1, {(VALUE_BITS-1){1'b0}}}) : '0;
          os_nxt = pst_r; st_nxt = P_IDLE;
        end
      end
      P_OUT: if (!busy) st_nxt = P_IDLE; // start done, no result
      default: st_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= P_IDLE; started_r <= 1'b0; ov_r <= 1'b0; second_r <= 1'b0;
    end else begin
      st_r <= st_nxt; started_r <= started_nxt; ov_r <= ov_nxt; second_r <= second_nxt;
    end
    vb_r <= vb_nxt; cur_r <= cur_nxt; om_r <= om_nxt; os_r <= os_nxt; mv_lo_r <= mv_lo_nxt;
    pst_r <= pst_nxt;
  end

  assign out_valid  = ov_r;
  assign out_median = om_r;
  assign out_status = os_r;

  a_bal: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == P_IDLE && started_r && !busy) |->
      (lst.count == ust.count + cnt_t'(1) || ust.count == lst.count + cnt_t'(1)))
    else $error("heaps unbalanced at rest");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r && $stable(om_r)) else $error("result lost");
  a_ok_started: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && os_r == ST_OK) |-> started_r) else $error("ok without set");
endmodule
